### rtl/tcw_pkg.sv
// shared constants, types and helpers of the text console writer
// no dependencies; every rtl file but tcw_ram refers to it by scoped names
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // field widths fixed by the ports
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int ADDR_W  = 11;
    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CMD_W   = 2;

    // one spare bit so a column or line can step past the edge before wrap
    localparam int COLX_W  = COL_W + 1;
    localparam int ROWX_W  = ROW_W + 1;

    localparam int TAB_STEP = 8;
    localparam logic [COLX_W-1:0] TAB_MASK = ~COLX_W'(TAB_STEP - 1);

    // command queue depth, a power of two
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // character codes with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRINT,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_LF,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] code;
        logic [ADDR_W-1:0] addr;
    } q_entry_t;

    // result beat, cursor_pos in the lowest bits
    typedef struct packed {
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [ADDR_W-1:0] cursor_pos;
    } res_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_READ,
        BK_COPY,
        BK_BLANK,
        BK_CLEAR
    } bk_state_t;

    function automatic logic [ADDR_W-1:0] cell_index(logic [ROW_W-1:0] line,
                                                     logic [COL_W-1:0] col);
        cell_index = ADDR_W'(line) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

### rtl/tcw_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tcw_front.sv
// front end: takes input beats and classifies them into queue entries
// depends on tcw_pkg
module tcw_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,
    input  logic [tcw_pkg::CMD_W-1:0] s_tuser,
    input  logic                      busy,
    input  logic                      q_full,
    output logic                      q_push,
    output tcw_pkg::q_entry_t         q_in
);

    logic [tcw_pkg::CHAR_W-1:0] code;
    logic [tcw_pkg::ADDR_W-1:0] addr;

    assign code = s_tdata[tcw_pkg::CHAR_W-1:0];
    assign addr = s_tdata[tcw_pkg::CHAR_W +: tcw_pkg::ADDR_W];

    assign s_tready = !busy && !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb
    begin
        q_in.code = code;
        q_in.addr = addr;
        q_in.op   = tcw_pkg::OP_NOP;
        case (s_tuser)
            tcw_pkg::CMD_PUT:
            begin
                case (code)
                    tcw_pkg::CH_BS:  q_in.op = tcw_pkg::OP_BS;
                    tcw_pkg::CH_TAB: q_in.op = tcw_pkg::OP_TAB;
                    tcw_pkg::CH_CR:  q_in.op = tcw_pkg::OP_CR;
                    tcw_pkg::CH_LF:  q_in.op = tcw_pkg::OP_LF;
                    default:
                    begin
                        if (code inside {[tcw_pkg::CH_SPACE:tcw_pkg::CH_DEL]})
                        begin
                            q_in.op = tcw_pkg::OP_PRINT;
                        end
                    end
                endcase
            end
            tcw_pkg::CMD_CLEAR: q_in.op = tcw_pkg::OP_CLEAR;
            tcw_pkg::CMD_READ:
            begin
                // out of range reads just report the cursor with zero data
                if (addr < tcw_pkg::ADDR_W'(tcw_pkg::CELLS))
                begin
                    q_in.op = tcw_pkg::OP_READ;
                end
            end
            default: q_in.op = tcw_pkg::OP_NOP;
        endcase
    end

endmodule

### rtl/tcw_queue.sv
// short queue of classified operations between front and back
// depends on tcw_pkg
module tcw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcw_pkg::q_entry_t din,
    output logic              full,
    input  logic              pop,
    output tcw_pkg::q_entry_t head,
    output logic              empty
);

    tcw_pkg::q_entry_t           entry_reg [tcw_pkg::QDEPTH];
    logic [tcw_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tcw_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tcw_pkg::QPTR_W:0]    count_reg, count_next;

    assign full  = count_reg == (tcw_pkg::QPTR_W + 1)'(tcw_pkg::QDEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### rtl/tcw_back.sv
// back end: cursor, screen store sequencer and result register
// depends on tcw_pkg and tcw_ram
module tcw_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0] attribute,
    input  logic                       q_empty,
    input  tcw_pkg::q_entry_t          q_head,
    output logic                       q_pop,
    output logic                       busy,
    output logic                       out_valid,
    input  logic                       out_ready,
    output tcw_pkg::res_t              out_res
);

    tcw_pkg::bk_state_t state_reg, state_next;

    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]  line_reg, line_next;
    logic [tcw_pkg::ADDR_W-1:0] cnt_reg, cnt_next;
    logic                       pend_reg, pend_next;
    logic [tcw_pkg::ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic                       out_valid_reg, out_valid_next;
    tcw_pkg::res_t              res_reg, res_next;

    logic [tcw_pkg::COLX_W-1:0] col_w;
    logic [tcw_pkg::ROWX_W-1:0] line_w;
    logic                       out_free;
    logic                       load_res;
    logic                       res_scr;
    logic [tcw_pkg::CELL_W-1:0] res_data;
    logic                       reading;

    logic                       ram_we;
    logic [tcw_pkg::ADDR_W-1:0] ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata;
    logic [tcw_pkg::ADDR_W-1:0] ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_rdata;

    tcw_ram #(
        .WIDTH(tcw_pkg::CELL_W),
        .DEPTH(tcw_pkg::CELLS)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign busy      = state_reg == tcw_pkg::BK_INIT;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pend_next    = 1'b0;
        wr_addr_next = wr_addr_reg;
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg;
        ram_wdata    = tcw_pkg::BLANK_CELL;
        ram_raddr    = q_head.addr;
        q_pop        = 1'b0;
        load_res     = 1'b0;
        res_scr      = 1'b0;
        res_data     = '0;
        reading      = 1'b0;
        col_w        = {1'b0, col_reg};
        line_w       = {1'b0, line_reg};

        case (state_reg)
            tcw_pkg::BK_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        tcw_pkg::OP_PRINT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = tcw_pkg::cell_index(line_reg, col_reg);
                            ram_wdata = {attribute, q_head.code};
                            col_w     = col_w + 1'b1;
                        end
                        tcw_pkg::OP_BS:
                        begin
                            if (col_reg != '0)
                            begin
                                col_w = col_w - 1'b1;
                            end
                        end
                        tcw_pkg::OP_TAB:
                        begin
                            col_w = (col_w + tcw_pkg::COLX_W'(tcw_pkg::TAB_STEP))
                                    & tcw_pkg::TAB_MASK;
                        end
                        tcw_pkg::OP_CR:
                        begin
                            col_w = '0;
                        end
                        tcw_pkg::OP_LF:
                        begin
                            col_w  = '0;
                            line_w = line_w + 1'b1;
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            col_w      = '0;
                            line_w     = '0;
                            cnt_next   = '0;
                            state_next = tcw_pkg::BK_CLEAR;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            state_next = tcw_pkg::BK_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                    // line wrap at the right edge
                    if (col_w >= tcw_pkg::COLX_W'(tcw_pkg::COLUMNS))
                    begin
                        col_w  = '0;
                        line_w = line_w + 1'b1;
                    end
                    // past the last row: scroll up through the store
                    if (line_w >= tcw_pkg::ROWX_W'(tcw_pkg::ROWS))
                    begin
                        line_w     = tcw_pkg::ROWX_W'(tcw_pkg::ROWS - 1);
                        cnt_next   = '0;
                        state_next = tcw_pkg::BK_COPY;
                    end
                    else if (state_next == tcw_pkg::BK_IDLE)
                    begin
                        load_res = 1'b1;
                    end
                end
            end
            tcw_pkg::BK_READ:
            begin
                load_res   = 1'b1;
                res_data   = ram_rdata;
                state_next = tcw_pkg::BK_IDLE;
            end
            tcw_pkg::BK_COPY:
            begin
                // read one row ahead, write the cell read last cycle
                reading   = cnt_reg < tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
                ram_raddr = cnt_reg + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (reading)
                begin
                    pend_next    = 1'b1;
                    wr_addr_next = cnt_reg;
                    cnt_next     = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = tcw_pkg::BK_BLANK;
                end
            end
            tcw_pkg::BK_BLANK:
            begin
                ram_we = 1'b1;
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    load_res   = 1'b1;
                    res_scr    = 1'b1;
                    state_next = tcw_pkg::BK_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tcw_pkg::BK_INIT,
            tcw_pkg::BK_CLEAR:
            begin
                ram_we = 1'b1;
                if (cnt_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    load_res   = state_reg == tcw_pkg::BK_CLEAR;
                    state_next = tcw_pkg::BK_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = tcw_pkg::BK_IDLE;
            end
        endcase

        col_next  = col_w[tcw_pkg::COL_W-1:0];
        line_next = line_w[tcw_pkg::ROW_W-1:0];

        res_next.cursor_pos = tcw_pkg::cell_index(line_next, col_next);
        res_next.cursor_row = line_next;
        res_next.cursor_col = col_next;
        res_next.scrolled   = res_scr;
        res_next.cell_data  = res_data;

        if (load_res)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::BK_INIT;
            col_reg       <= '0;
            line_reg      <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

    // a new result never lands on one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |-> out_free)
        else $error("result register overwritten");

    // cursor stays on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (line_reg < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
        && (col_reg < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)))
        else $error("cursor off screen");

    // operations are only taken from the queue when idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == tcw_pkg::BK_IDLE) && !q_empty)
        else $error("queue popped outside idle");

    // the row copy always hands over to blanking the bottom row
    a_copy_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcw_pkg::BK_COPY) |=>
        (state_reg == tcw_pkg::BK_COPY) || (state_reg == tcw_pkg::BK_BLANK))
        else $error("scroll copy left early");

    // reported linear position matches row and column
    a_pos_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        res_reg.cursor_pos == tcw_pkg::cell_index(res_reg.cursor_row, res_reg.cursor_col))
        else $error("cursor position mismatch");

endmodule

### rtl/text_console_writer_core.sv
// top level of the text console writer
// depends on tcw_pkg, tcw_front, tcw_queue, tcw_back and tcw_ram
//
// An 80x25 text console with a 2000-cell store of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor. Every input beat
// gives exactly one result beat with the cursor after the command, a scroll
// flag and, for reads, the cell. A front stage classifies incoming beats into
// a two-entry queue; the back sequencer owns the cursor and the store memory,
// which has one write and one registered read port, and that port sets the
// timing: a read waits for the registered read data, and a put character that
// scrolls copies the rows up at one cell per cycle, then blanks the bottom row;
// a clear blanks every cell. After reset a clearing pass blanks the store to
// 0x0F20 and s_tready stays low meanwhile; attribute writes are still taken.
// The queue takes new commands while a result waits; the back sequencer starts
// the next one only when the result register is free or its beat is taken.
module text_console_writer_core (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration: attribute byte
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [7:0]                cfg_data,
    // input beats
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,    // char_code[7:0], cell_address[18:8]
    input  logic [1:0]                s_tuser,    // command[1:0]
    // result beats
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [39:0]               m_tdata     // cursor_pos[10:0], cursor_row[15:11],
                                                  // cursor_col[22:16], scrolled[23],
                                                  // cell_data[39:24]
);

    logic [tcw_pkg::ATTR_W-1:0] attr_reg, attr_next;

    logic              busy;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    tcw_pkg::q_entry_t q_in;
    tcw_pkg::q_entry_t q_head;
    tcw_pkg::res_t     res;

    // attribute writes are always taken
    assign cfg_ready = 1'b1;
    assign attr_next = (cfg_valid && cfg_ready) ? cfg_data : attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= tcw_pkg::ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    // classify and queue incoming commands
    tcw_front u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .busy    (busy),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_in    (q_in)
    );

    tcw_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .din  (q_in),
        .full (q_full),
        .pop  (q_pop),
        .head (q_head),
        .empty(q_empty)
    );

    // cursor, store sequencing and result beat
    tcw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .attribute(attr_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .busy     (busy),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (res)
    );

    // result struct is laid out with cursor_pos in the lowest bits
    assign m_tdata = res;

endmodule
